FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg - shared definitions for the stable priority queue
// Sizes, request and status codes, and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Queue geometry
   localparam int DEPTH        = 16;
   localparam int MAX_PRIORITY = 9;
   localparam int MIN_PRIORITY = 1;

   // Field widths
   localparam int PRIO_W = 4;
   localparam int MSG_W  = 16;
   localparam int OCC_W  = 5;
   localparam int STAT_W = 3;
   localparam int KIND_W = 2;

   // Slot index and entry count widths
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Request kinds
   typedef enum logic [KIND_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_PEEK   = 2'd2,
      REQ_SEARCH = 2'd3
   } req_kind_type;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_BAD_PRIO  = 3'd4
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic exec;
      logic scan;
      logic load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic needs_scan;
      logic scan_done;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath - slot registers, request register and result registers
// Holds the sorted entry list, applies insert and remove as one parallel
// shift, walks the list one slot a cycle for a search, and keeps the
// output register of the result channel.
// ----------------------------------------------------------------------------
module spq_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  spq_pkg::cmd_type           cmd,
   output spq_pkg::dp_stat_type       stat,
   input  logic [spq_pkg::KIND_W-1:0] req_kind,
   input  logic [spq_pkg::PRIO_W-1:0] req_prio,
   input  logic [spq_pkg::MSG_W-1:0]  req_msg,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [spq_pkg::STAT_W-1:0] rsp_status,
   output logic [spq_pkg::PRIO_W-1:0] rsp_prio,
   output logic [spq_pkg::MSG_W-1:0]  rsp_msg,
   output logic [spq_pkg::OCC_W-1:0]  rsp_occ
);
   import spq_pkg::*;

   // Entry list, head in slot 0
   logic [PRIO_W-1:0] slot_prio_ff [DEPTH];
   logic [PRIO_W-1:0] slot_prio_in [DEPTH];
   logic [MSG_W-1:0]  slot_msg_ff  [DEPTH];
   logic [MSG_W-1:0]  slot_msg_in  [DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;

   // Captured request
   req_kind_type      kind_ff, kind_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [MSG_W-1:0]  msg_ff, msg_in;

   // Search pointer and staged result
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   status_type        res_status_ff, res_status_in;
   logic [PRIO_W-1:0] res_prio_ff, res_prio_in;
   logic [MSG_W-1:0]  res_msg_ff, res_msg_in;

   // Output register
   logic              out_valid_ff, out_valid_in;
   logic [STAT_W-1:0] out_status_ff, out_status_in;
   logic [PRIO_W-1:0] out_prio_ff, out_prio_in;
   logic [MSG_W-1:0]  out_msg_ff, out_msg_in;
   logic [OCC_W-1:0]  out_occ_ff, out_occ_in;

   logic              prio_ok, full, empty, hit, last;
   logic [DEPTH-1:0]  ge;
   logic [PRIO_W-1:0] rd_prio;
   logic [MSG_W-1:0]  rd_msg;
   logic              out_free;

   // Decode request conditions
   always_comb begin
      prio_ok = (prio_ff >= PRIO_W'(MIN_PRIORITY)) && (prio_ff <= PRIO_W'(MAX_PRIORITY));
      full    = (count_ff == CNT_W'(DEPTH));
      empty   = (count_ff == '0);
      for (int i = 0; i < DEPTH; i++) begin
         ge[i] = (CNT_W'(i) < count_ff) && (slot_prio_ff[i] >= prio_ff);
      end
      rd_prio  = slot_prio_ff[scan_idx_ff];
      rd_msg   = slot_msg_ff[scan_idx_ff];
      hit      = (rd_prio == prio_ff);
      last     = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff);
      out_free = !out_valid_ff || rsp_ready;
   end

   assign stat.needs_scan = (kind_ff == REQ_SEARCH) && prio_ok && !empty;
   assign stat.scan_done  = hit || last;
   assign stat.out_free   = out_free;

   // Next-state logic for list, request and result
   always_comb begin
      slot_prio_in  = slot_prio_ff;
      slot_msg_in   = slot_msg_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      prio_in       = prio_ff;
      msg_in        = msg_ff;
      scan_idx_in   = scan_idx_ff;
      res_status_in = res_status_ff;
      res_prio_in   = res_prio_ff;
      res_msg_in    = res_msg_ff;

      // Capture accepted beat
      if (cmd.load_req) begin
         kind_in = req_kind_type'(req_kind);
         prio_in = req_prio;
         msg_in  = req_msg;
      end

      // Serve the request
      if (cmd.exec) begin
         res_status_in = ST_OK;
         res_prio_in   = '0;
         res_msg_in    = '0;
         scan_idx_in   = '0;
         case (kind_ff)
            REQ_INSERT: begin
               if (!prio_ok) begin
                  res_status_in = ST_BAD_PRIO;
               end else if (full) begin
                  res_status_in = ST_FULL;
               end else begin
                  // Keep higher-or-equal entries, drop new one in, shift the rest back
                  if (!ge[0]) begin
                     slot_prio_in[0] = prio_ff;
                     slot_msg_in[0]  = msg_ff;
                  end
                  for (int i = 1; i < DEPTH; i++) begin
                     if (!ge[i]) begin
                        slot_prio_in[i] = ge[i-1] ? prio_ff : slot_prio_ff[i-1];
                        slot_msg_in[i]  = ge[i-1] ? msg_ff  : slot_msg_ff[i-1];
                     end
                  end
                  count_in = count_ff + CNT_W'(1);
               end
            end
            REQ_REMOVE: begin
               if (empty) begin
                  res_status_in = ST_EMPTY;
               end else begin
                  res_prio_in = slot_prio_ff[0];
                  res_msg_in  = slot_msg_ff[0];
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     slot_prio_in[i] = slot_prio_ff[i+1];
                     slot_msg_in[i]  = slot_msg_ff[i+1];
                  end
                  count_in = count_ff - CNT_W'(1);
               end
            end
            REQ_PEEK: begin
               if (empty) begin
                  res_status_in = ST_EMPTY;
               end else begin
                  res_prio_in = slot_prio_ff[0];
                  res_msg_in  = slot_msg_ff[0];
               end
            end
            REQ_SEARCH: begin
               if (!prio_ok) begin
                  res_status_in = ST_BAD_PRIO;
               end else if (empty) begin
                  res_status_in = ST_EMPTY;
               end else begin
                  res_status_in = ST_NOT_FOUND;
               end
            end
            default: begin
               res_status_in = ST_BAD_PRIO;
            end
         endcase
      end

      // Walk one slot per cycle until a match or the tail
      if (cmd.scan) begin
         if (hit) begin
            res_status_in = ST_OK;
            res_prio_in   = rd_prio;
            res_msg_in    = rd_msg;
         end else if (!last) begin
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
      end
   end

   // Output register load and drain
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_prio_in   = out_prio_ff;
      out_msg_in    = out_msg_ff;
      out_occ_in    = out_occ_ff;
      if (cmd.load_out) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_prio_in   = res_prio_ff;
         out_msg_in    = res_msg_ff;
         out_occ_in    = OCC_W'(count_ff);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      slot_prio_ff  <= slot_prio_in;
      slot_msg_ff   <= slot_msg_in;
      kind_ff       <= kind_in;
      prio_ff       <= prio_in;
      msg_ff        <= msg_in;
      scan_idx_ff   <= scan_idx_in;
      res_status_ff <= res_status_in;
      res_prio_ff   <= res_prio_in;
      res_msg_ff    <= res_msg_in;
      out_status_ff <= out_status_in;
      out_prio_ff   <= out_prio_in;
      out_msg_ff    <= out_msg_in;
      out_occ_ff    <= out_occ_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_prio   = out_prio_ff;
   assign rsp_msg    = out_msg_ff;
   assign rsp_occ    = out_occ_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> out_free)
      else $error("result loaded over a pending beat");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && kind_ff == REQ_INSERT && prio_ok && !full)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not add an entry");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && kind_ff == REQ_REMOVE && !empty)
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("remove did not drop an entry");

endmodule

FILE: rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl - request sequencer for the stable priority queue
// Takes one request beat, runs the operation, steps the search
// walk, and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  spq_pkg::dp_stat_type stat,
   output spq_pkg::cmd_type     cmd
);
   import spq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   // Sequence one request
   always_comb begin
      state_in     = state_ff;
      ready_in     = ready_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            ready_in = 1'b1;
            if (req_valid && ready_ff) begin
               cmd.load_req = 1'b1;
               ready_in     = 1'b0;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.needs_scan ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               ready_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            ready_in = 1'b0;
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

FILE: rtl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue - bounded priority queue of message handles
// Sorted list of up to 16 entries, highest priority at the head, equal
// priorities kept in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as beats on the req_ channel: the request kind in
//   req_tuser (insert, remove head, peek head, search by priority) and the
//   priority and message handle in req_tdata. Every request returns exactly
//   one beat on the rsp_ channel with status, returned priority and handle,
//   and the occupancy after the request.
//   An insert, remove or peek request is accepted, executed, and its result
//   then loaded into the output register; no new request is taken until
//   that result is loaded. A search walks the list one slot per cycle from
//   the head, up to and including the matching slot or the tail.
//   While the receiver stalls, the result beat is held in the output
//   register; one more request is accepted and executed, then the block
//   waits with req_tready low until the pending beat is taken.
//   Reset empties the queue; req_tready rises in the cycle after reset ends.
// ----------------------------------------------------------------------------
module stable_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   input  logic [23:0] req_tdata,   // priority_req[3:0], message_handle[19:4], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // status[2:0], out_priority[6:3], out_message[22:7],
                                    // occupancy[27:23], zero pad
);
   import spq_pkg::*;

   cmd_type           cmd;
   dp_stat_type       stat;
   logic [STAT_W-1:0] rsp_status;
   logic [PRIO_W-1:0] rsp_prio;
   logic [MSG_W-1:0]  rsp_msg;
   logic [OCC_W-1:0]  rsp_occ;

   // Sequencer
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Entry list and result path
   spq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_tuser[KIND_W-1:0]),
      .req_prio   (req_tdata[PRIO_W-1:0]),
      .req_msg    (req_tdata[PRIO_W+MSG_W-1:PRIO_W]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_prio   (rsp_prio),
      .rsp_msg    (rsp_msg),
      .rsp_occ    (rsp_occ)
   );

   // Pack the result beat
   assign rsp_tdata = {4'b0, rsp_occ, rsp_msg, rsp_prio, rsp_status};

endmodule
